>>> rtl/core/tbds_pkg.sv
// ----------------------------------------------------------------------------
// tbds_pkg
// Shared widths, command and status codes, and the structs that pass between
// the tile binning sorter's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tbds_pkg;

    // Store sizes
    localparam int MAX_ENTRIES   = 4096;
    localparam int MAX_GAUSSIANS = 4096;
    localparam int MAX_TILES     = 256;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;
    localparam int GAUSS_W  = 12;
    localparam int TILE_W   = 8;
    localparam int DEPTH_W  = 32;
    localparam int POS_W    = 12;
    localparam int CNT_W    = 13;
    localparam int ADDR_W   = 12;
    localparam int NT_W     = 9;
    localparam int CFG_W    = 9;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Radix sort geometry
    localparam int RADIX_BITS    = 8;
    localparam int RADIX_BUCKETS = 256;
    localparam int RADIX_PASSES  = 4;
    localparam int PASS_W        = 3;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_SET_DEPTH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SORT        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ_SORTED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_RANGE  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TILE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_GAUSS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd4;

    // Register index, taken from paddr bit 2
    localparam logic CFG_IDX_ACROSS = 1'b0;
    localparam logic CFG_IDX_DOWN   = 1'b1;

    // One entry while it is being sorted
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [TILE_W-1:0]  tile;
        logic [GAUSS_W-1:0] gauss;
    } sort_item_t;

    // Range of one tile in the sorted output
    typedef struct packed {
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] count;
    } tile_range_t;

    // Writes into the depth and entry stores
    typedef struct packed {
        logic               dep_we;
        logic [ADDR_W-1:0]  dep_addr;
        logic [DEPTH_W-1:0] dep_data;
        logic               ent_we;
        logic [ADDR_W-1:0]  ent_addr;
        logic [GAUSS_W-1:0] ent_gauss;
        logic [TILE_W-1:0]  ent_tile;
    } mem_wr_t;

    // Load reads issued by the sorter
    typedef struct packed {
        logic              ent_rd;
        logic [ADDR_W-1:0] ent_addr;
        logic              dep_rd;
        logic [ADDR_W-1:0] dep_addr;
    } ld_req_t;

    typedef struct packed {
        logic [GAUSS_W-1:0] gauss;
        logic [TILE_W-1:0]  tile;
        logic [DEPTH_W-1:0] depth;
    } ld_rsp_t;

    // Sort start and status
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic [NT_W-1:0]  tiles;
    } sort_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] count;
    } sort_sts_t;

    // Reads of the sorted output
    typedef struct packed {
        logic              pos_rd;
        logic [ADDR_W-1:0] pos;
        logic              tile_rd;
        logic [TILE_W-1:0] tile;
    } query_t;

    typedef struct packed {
        logic [GAUSS_W-1:0] gauss;
        logic [CNT_W-1:0]   start;
        logic [CNT_W-1:0]   count;
    } query_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/tbds_cmd_if.sv
// ----------------------------------------------------------------------------
// tbds_cmd_if
// Command channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbds_cmd_if import tbds_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [GAUSS_W-1:0] gaussian_index;
    logic [TILE_W-1:0]  tile_index;
    logic [DEPTH_W-1:0] depth_key;
    logic [POS_W-1:0]   position;

    modport source (
        output valid, mode, gaussian_index, tile_index, depth_key, position,
        input  ready
    );

    modport sink (
        input  valid, mode, gaussian_index, tile_index, depth_key, position,
        output ready
    );

endinterface

`default_nettype wire

>>> rtl/core/tbds_rsp_if.sv
// ----------------------------------------------------------------------------
// tbds_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbds_rsp_if import tbds_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [GAUSS_W-1:0]  sorted_gaussian;
    logic [CNT_W-1:0]    range_start;
    logic [CNT_W-1:0]    range_end;
    logic [CNT_W-1:0]    entry_total;

    modport source (
        output valid, status, sorted_gaussian, range_start, range_end, entry_total,
        input  ready
    );

    modport sink (
        input  valid, status, sorted_gaussian, range_start, range_end, entry_total,
        output ready
    );

endinterface

`default_nettype wire

>>> rtl/core/tbds_entry_mem.sv
// ----------------------------------------------------------------------------
// tbds_entry_mem
// Depth store and append store: one write and one registered read per cycle
// on each memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tbds_entry_mem import tbds_pkg::*; (
    input  logic    clk,
    input  mem_wr_t wr,
    input  ld_req_t req,
    output ld_rsp_t rsp
);

    logic [DEPTH_W-1:0]        depth_mem [MAX_GAUSSIANS];
    logic [GAUSS_W+TILE_W-1:0] ent_mem   [MAX_ENTRIES];
    logic [DEPTH_W-1:0]        dep_q;
    logic [GAUSS_W+TILE_W-1:0] ent_q;

    // Depth per gaussian
    always_ff @(posedge clk)
    begin
        if (wr.dep_we)
        begin
            depth_mem[wr.dep_addr] <= wr.dep_data;
        end
        if (req.dep_rd)
        begin
            dep_q <= depth_mem[req.dep_addr];
        end
    end

    // Appended entries in append order
    always_ff @(posedge clk)
    begin
        if (wr.ent_we)
        begin
            ent_mem[wr.ent_addr] <= {wr.ent_gauss, wr.ent_tile};
        end
        if (req.ent_rd)
        begin
            ent_q <= ent_mem[req.ent_addr];
        end
    end

    assign rsp.gauss = ent_q[GAUSS_W+TILE_W-1:TILE_W];
    assign rsp.tile  = ent_q[TILE_W-1:0];
    assign rsp.depth = dep_q;

endmodule

`default_nettype wire

>>> rtl/core/tbds_sorter.sv
// ----------------------------------------------------------------------------
// tbds_sorter
// Gathers the appended entries, then runs a stable LSD radix sort over the
// four depth bytes and finally the tile byte, ping-ponging two buffers.
// Holds the sorted output and the per-tile ranges for later reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tbds_sorter import tbds_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  sort_ctl_t  ctl,
    output sort_sts_t  sts,
    output ld_req_t    ld_req,
    input  ld_rsp_t    ld_rsp,
    input  query_t     qry,
    output query_rsp_t qrsp
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_LD_RD   = 13'b0000000000010,
        S_LD_DEP  = 13'b0000000000100,
        S_LD_WR   = 13'b0000000001000,
        S_CLR     = 13'b0000000010000,
        S_CNT_RD  = 13'b0000000100000,
        S_CNT_BKT = 13'b0000001000000,
        S_CNT_WR  = 13'b0000010000000,
        S_PRE_RD  = 13'b0000100000000,
        S_PRE_WR  = 13'b0001000000000,
        S_SCT_RD  = 13'b0010000000000,
        S_SCT_BKT = 13'b0100000000000,
        S_SCT_WR  = 13'b1000000000000
    } sort_state_t;

    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(RADIX_PASSES);
    localparam logic [RADIX_BITS-1:0] LAST_BKT = RADIX_BITS'(RADIX_BUCKETS - 1);

    sort_state_t           state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      tot_reg, tot_next;
    logic [CNT_W-1:0]      sum_reg, sum_next;
    logic [NT_W-1:0]       nt_reg, nt_next;
    logic [PASS_W-1:0]     pass_reg, pass_next;
    logic [RADIX_BITS-1:0] bkt_idx_reg, bkt_idx_next;
    logic [RADIX_BITS-1:0] digit_reg, digit_next;
    sort_item_t            item_reg, item_next;
    logic                  ranges_valid_reg, ranges_valid_next;
    logic                  done;

    // Memories and their ports
    sort_item_t  buf_a    [MAX_ENTRIES];
    sort_item_t  buf_b    [MAX_ENTRIES];
    logic [CNT_W-1:0] bkt_mem [RADIX_BUCKETS];
    tile_range_t tile_mem [MAX_TILES];

    logic                  a_we, a_re, b_we, b_re;
    logic [ADDR_W-1:0]     a_waddr, a_raddr, b_waddr, b_raddr;
    sort_item_t            a_wdata, b_wdata, a_q, b_q, src_q;
    logic                  bkt_we, bkt_re;
    logic [RADIX_BITS-1:0] bkt_waddr, bkt_raddr;
    logic [CNT_W-1:0]      bkt_wdata, bkt_q;
    logic                  tile_we, tile_re;
    logic [TILE_W-1:0]     tile_waddr, tile_raddr;
    tile_range_t           tile_wdata, tile_q;

    // Byte of the key that the current pass sorts on
    function automatic logic [RADIX_BITS-1:0] key_digit(
        input sort_item_t        it,
        input logic [PASS_W-1:0] pass
    );
        logic [RADIX_BITS-1:0] d;
        if (pass[PASS_W-1])
        begin
            d = it.tile;
        end
        else
        begin
            d = it.depth[{pass[1:0], 3'b000} +: RADIX_BITS];
        end
        return d;
    endfunction

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            buf_a[a_waddr] <= a_wdata;
        end
        if (a_re)
        begin
            a_q <= buf_a[a_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            buf_b[b_waddr] <= b_wdata;
        end
        if (b_re)
        begin
            b_q <= buf_b[b_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
        begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re)
        begin
            bkt_q <= bkt_mem[bkt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tile_we)
        begin
            tile_mem[tile_waddr] <= tile_wdata;
        end
        if (tile_re)
        begin
            tile_q <= tile_mem[tile_raddr];
        end
    end

    // Even passes read buffer A, odd passes read buffer B
    assign src_q = pass_reg[0] ? b_q : a_q;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        n_next            = n_reg;
        tot_next          = tot_reg;
        sum_next          = sum_reg;
        nt_next           = nt_reg;
        pass_next         = pass_reg;
        bkt_idx_next      = bkt_idx_reg;
        digit_next        = digit_reg;
        item_next         = item_reg;
        ranges_valid_next = ranges_valid_reg;
        done              = 1'b0;
        ld_req            = '0;
        a_we = 1'b0; a_re = 1'b0; a_waddr = '0; a_raddr = '0; a_wdata = item_reg;
        b_we = 1'b0; b_re = 1'b0; b_waddr = '0; b_raddr = '0; b_wdata = item_reg;
        bkt_we = 1'b0; bkt_re = 1'b0; bkt_waddr = digit_reg; bkt_raddr = bkt_idx_reg;
        bkt_wdata = '0;
        tile_we = 1'b0; tile_re = 1'b0; tile_waddr = bkt_idx_reg; tile_raddr = qry.tile;
        tile_wdata = '{start: sum_reg, count: bkt_q};

        unique case (state_reg)
            S_IDLE:
            begin
                // Serve reads of the sorted output
                b_re    = qry.pos_rd;
                b_raddr = qry.pos;
                tile_re = qry.tile_rd;
                if (ctl.start)
                begin
                    tot_next   = ctl.count;
                    nt_next    = ctl.tiles;
                    idx_next   = '0;
                    n_next     = '0;
                    pass_next  = '0;
                    state_next = S_LD_RD;
                end
            end
            S_LD_RD:
            begin
                if (idx_reg == tot_reg)
                begin
                    bkt_idx_next = '0;
                    state_next   = S_CLR;
                end
                else
                begin
                    ld_req.ent_rd   = 1'b1;
                    ld_req.ent_addr = idx_reg[ADDR_W-1:0];
                    state_next      = S_LD_DEP;
                end
            end
            S_LD_DEP:
            begin
                // Drop entries whose tile is no longer in use
                if ({1'b0, ld_rsp.tile} < nt_reg)
                begin
                    ld_req.dep_rd   = 1'b1;
                    ld_req.dep_addr = ld_rsp.gauss;
                    state_next      = S_LD_WR;
                end
                else
                begin
                    idx_next   = CNT_W'(idx_reg + 1'b1);
                    state_next = S_LD_RD;
                end
            end
            S_LD_WR:
            begin
                a_we       = 1'b1;
                a_waddr    = n_reg[ADDR_W-1:0];
                a_wdata    = '{depth: ld_rsp.depth, tile: ld_rsp.tile, gauss: ld_rsp.gauss};
                n_next     = CNT_W'(n_reg + 1'b1);
                idx_next   = CNT_W'(idx_reg + 1'b1);
                state_next = S_LD_RD;
            end
            S_CLR:
            begin
                bkt_we       = 1'b1;
                bkt_waddr    = bkt_idx_reg;
                bkt_idx_next = RADIX_BITS'(bkt_idx_reg + 1'b1);
                if (bkt_idx_reg == LAST_BKT)
                begin
                    idx_next   = '0;
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    bkt_idx_next = '0;
                    sum_next     = '0;
                    state_next   = S_PRE_RD;
                end
                else
                begin
                    a_re       = !pass_reg[0];
                    b_re       = pass_reg[0];
                    a_raddr    = idx_reg[ADDR_W-1:0];
                    b_raddr    = idx_reg[ADDR_W-1:0];
                    state_next = S_CNT_BKT;
                end
            end
            S_CNT_BKT:
            begin
                digit_next = key_digit(src_q, pass_reg);
                bkt_re     = 1'b1;
                bkt_raddr  = key_digit(src_q, pass_reg);
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                bkt_we     = 1'b1;
                bkt_wdata  = CNT_W'(bkt_q + 1'b1);
                idx_next   = CNT_W'(idx_reg + 1'b1);
                state_next = S_CNT_RD;
            end
            S_PRE_RD:
            begin
                bkt_re     = 1'b1;
                state_next = S_PRE_WR;
            end
            S_PRE_WR:
            begin
                // Turn counts into start positions; the tile pass also keeps ranges
                bkt_we       = 1'b1;
                bkt_waddr    = bkt_idx_reg;
                bkt_wdata    = sum_reg;
                tile_we      = (pass_reg == LAST_PASS);
                sum_next     = CNT_W'(sum_reg + bkt_q);
                bkt_idx_next = RADIX_BITS'(bkt_idx_reg + 1'b1);
                if (bkt_idx_reg == LAST_BKT)
                begin
                    idx_next   = '0;
                    state_next = S_SCT_RD;
                end
                else
                begin
                    state_next = S_PRE_RD;
                end
            end
            S_SCT_RD:
            begin
                if (idx_reg == n_reg)
                begin
                    if (pass_reg == LAST_PASS)
                    begin
                        done              = 1'b1;
                        ranges_valid_next = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        pass_next    = PASS_W'(pass_reg + 1'b1);
                        bkt_idx_next = '0;
                        state_next   = S_CLR;
                    end
                end
                else
                begin
                    a_re       = !pass_reg[0];
                    b_re       = pass_reg[0];
                    a_raddr    = idx_reg[ADDR_W-1:0];
                    b_raddr    = idx_reg[ADDR_W-1:0];
                    state_next = S_SCT_BKT;
                end
            end
            S_SCT_BKT:
            begin
                item_next  = src_q;
                digit_next = key_digit(src_q, pass_reg);
                bkt_re     = 1'b1;
                bkt_raddr  = key_digit(src_q, pass_reg);
                state_next = S_SCT_WR;
            end
            S_SCT_WR:
            begin
                // Place the item and advance its bucket
                a_we       = pass_reg[0];
                b_we       = !pass_reg[0];
                a_waddr    = bkt_q[ADDR_W-1:0];
                b_waddr    = bkt_q[ADDR_W-1:0];
                bkt_we     = 1'b1;
                bkt_wdata  = CNT_W'(bkt_q + 1'b1);
                idx_next   = CNT_W'(idx_reg + 1'b1);
                state_next = S_SCT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ranges_valid_reg <= 1'b0;
            idx_reg          <= '0;
            n_reg            <= '0;
            tot_reg          <= '0;
            pass_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            ranges_valid_reg <= ranges_valid_next;
            idx_reg          <= idx_next;
            n_reg            <= n_next;
            tot_reg          <= tot_next;
            pass_reg         <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        nt_reg      <= nt_next;
        bkt_idx_reg <= bkt_idx_next;
        digit_reg   <= digit_next;
        item_reg    <= item_next;
    end

    assign sts.busy  = (state_reg != S_IDLE);
    assign sts.done  = done;
    assign sts.count = n_reg;

    // Tiles read as empty until the first sort has written the ranges
    assign qrsp.gauss = b_q.gauss;
    assign qrsp.start = ranges_valid_reg ? tile_q.start : '0;
    assign qrsp.count = ranges_valid_reg ? tile_q.count : '0;

endmodule

`default_nettype wire

>>> rtl/core/tile_bin_depth_sort_top.sv
// ----------------------------------------------------------------------------
// tile_bin_depth_sort_top
// Tile binning depth sorter: command decode, configuration and result stage.
//
// Commands enter on cmd and each gives exactly one item on rsp, in order.
// Set depth, append, read sorted and read range commands pass through the
// pending stage and then the result register, and a new command is taken
// every cycle while rsp.ready stays high and no sort is running.
// A sort command walks the stores: it gathers the appended entries whose
// tile is in use, then runs five radix passes that each clear the bucket
// memory, count, turn counts into start positions and scatter the kept
// entries, read-modify-write on single-port-read memories. Its result item
// follows the end of the sort; cmd.ready is low meanwhile.
// The APB port writes tiles_across at 0x0 and tiles_down at 0x4; write
// them only while no command is in flight.
// Reset sets both registers to 16, clears the counts and makes every tile
// read as empty; the depth, entry and sorted stores need no clearing.
// When rsp stalls the result item holds, one more command waits in the
// pending stage, and cmd.ready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_bin_depth_sort_top import tbds_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    tbds_cmd_if.sink           cmd,
    tbds_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CFG_W-1:0]    across_reg, down_reg;
    logic [2*CFG_W-1:0]  tile_prod;
    logic [NT_W-1:0]     tiles_used;
    logic                cfg_we, accept, in_ready, tile_ok, p1_adv;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [CNT_W-1:0]    sorted_count_reg;
    logic                p1_valid_reg;
    logic [MODE_W-1:0]   p1_mode_reg;
    logic [STATUS_W-1:0] p1_status_reg, status_next;
    logic [CNT_W-1:0]    p1_total_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [GAUSS_W-1:0]  out_gauss_reg;
    logic [CNT_W-1:0]    out_start_reg, out_end_reg, out_total_reg;

    mem_wr_t    wr;
    ld_req_t    ld_req;
    ld_rsp_t    ld_rsp;
    sort_ctl_t  ctl;
    sort_sts_t  sts;
    query_t     qry;
    query_rsp_t qrsp;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            across_reg <= CFG_W'(16);
            down_reg   <= CFG_W'(16);
        end
        else if (cfg_we)
        begin
            if (paddr[2] == CFG_IDX_ACROSS)
            begin
                across_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                down_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            CFG_IDX_ACROSS: prdata = PDATA_W'(across_reg);
            CFG_IDX_DOWN:   prdata = PDATA_W'(down_reg);
            default:        prdata = '0;
        endcase
    end

    // Tiles in use, saturated at the tile store size
    assign tile_prod  = across_reg * down_reg;
    assign tiles_used = (tile_prod > (2*CFG_W)'(MAX_TILES)) ? NT_W'(MAX_TILES)
                                                            : tile_prod[NT_W-1:0];

    // Handshake: hold commands while sorting or while the pending stage is stuck
    assign p1_adv    = p1_valid_reg && !sts.busy && (!out_valid_reg || rsp.ready);
    assign in_ready  = !sts.busy && (!p1_valid_reg || p1_adv);
    assign cmd.ready = in_ready;
    assign accept    = cmd.valid && in_ready;
    assign tile_ok   = ({1'b0, cmd.tile_index} < tiles_used);

    // Decode an accepted command; a 12-bit gaussian index is always in range
    always_comb
    begin
        status_next      = ST_OK;
        entry_count_next = entry_count_reg;
        wr               = '0;
        wr.dep_addr      = cmd.gaussian_index;
        wr.dep_data      = cmd.depth_key;
        wr.ent_addr      = entry_count_reg[ADDR_W-1:0];
        wr.ent_gauss     = cmd.gaussian_index;
        wr.ent_tile      = cmd.tile_index;
        ctl.start        = 1'b0;
        ctl.count        = entry_count_reg;
        ctl.tiles        = tiles_used;
        qry.pos_rd       = 1'b0;
        qry.pos          = cmd.position;
        qry.tile_rd      = 1'b0;
        qry.tile         = cmd.tile_index;
        if (accept)
        begin
            unique case (cmd.mode)
                MODE_SET_DEPTH:
                begin
                    wr.dep_we = 1'b1;
                end
                MODE_APPEND:
                begin
                    if (!tile_ok)
                    begin
                        status_next = ST_BAD_TILE;
                    end
                    else if (entry_count_reg >= CNT_W'(MAX_ENTRIES))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr.ent_we        = 1'b1;
                        entry_count_next = CNT_W'(entry_count_reg + 1'b1);
                    end
                end
                MODE_SORT:
                begin
                    ctl.start        = 1'b1;
                    entry_count_next = '0;
                end
                MODE_READ_SORTED:
                begin
                    if ({1'b0, cmd.position} >= sorted_count_reg)
                    begin
                        status_next = ST_BAD_POS;
                    end
                    else
                    begin
                        qry.pos_rd = 1'b1;
                    end
                end
                MODE_READ_RANGE:
                begin
                    if (!tile_ok)
                    begin
                        status_next = ST_BAD_TILE;
                    end
                    else
                    begin
                        qry.tile_rd = 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Counters and the valid flags of the two result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= '0;
            sorted_count_reg <= '0;
            p1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            if (sts.done)
            begin
                sorted_count_reg <= sts.count;
            end
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pending stage: hold the command while its memory read completes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_mode_reg   <= cmd.mode;
            p1_status_reg <= status_next;
            p1_total_reg  <= entry_count_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (p1_adv)
        begin
            out_status_reg <= p1_status_reg;
            out_gauss_reg  <= '0;
            out_start_reg  <= '0;
            out_end_reg    <= '0;
            if (p1_mode_reg == MODE_READ_SORTED && p1_status_reg == ST_OK)
            begin
                out_gauss_reg <= qrsp.gauss;
            end
            if (p1_mode_reg == MODE_READ_RANGE && p1_status_reg == ST_OK
                && qrsp.count != '0)
            begin
                out_start_reg <= qrsp.start;
                out_end_reg   <= CNT_W'(qrsp.start + qrsp.count);
            end
            if (p1_mode_reg == MODE_SORT || p1_mode_reg == MODE_READ_SORTED
                || p1_mode_reg == MODE_READ_RANGE)
            begin
                out_total_reg <= sorted_count_reg;
            end
            else
            begin
                out_total_reg <= p1_total_reg;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.sorted_gaussian = out_gauss_reg;
    assign rsp.range_start     = out_start_reg;
    assign rsp.range_end       = out_end_reg;
    assign rsp.entry_total     = out_total_reg;

    tbds_entry_mem u_entry_mem (
        .clk (clk),
        .wr  (wr),
        .req (ld_req),
        .rsp (ld_rsp)
    );

    tbds_sorter u_sorter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sts    (sts),
        .ld_req (ld_req),
        .ld_rsp (ld_rsp),
        .qry    (qry),
        .qrsp   (qrsp)
    );

`ifndef SYNTHESIS
    a_busy_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        sts.busy |-> !in_ready)
        else $error("command taken during a sort");

    a_busy_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        sts.busy |-> (entry_count_reg == '0))
        else $error("append count not cleared during a sort");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("append count beyond store size");

    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> (sorted_count_reg == $past(sts.count)))
        else $error("sorted count not taken at end of sort");
`endif

endmodule

`default_nettype wire
